### design/tac_pkg.sv
// ----------------------------------------------------------------------------
// tac_pkg
// Shared types, constants and helpers of the two-way association counter.
// ----------------------------------------------------------------------------
package tac_pkg;

    localparam int TXT_W       = 120;
    localparam int TXT_BYTES   = 15;
    localparam int LEN_W       = 4;
    localparam int CNT_W       = 32;
    localparam int NA_W        = 4;
    localparam int CAP         = 64;
    localparam int N_W         = 7;
    localparam int LIMIT_W     = 9;
    localparam int DEF_ENTRIES = 256;
    localparam int DEF_ASSOC   = 8;
    localparam int OUT_DATA_W  = 160;
    localparam int OUT_USER_W  = 4;
    localparam int IN_DATA_W   = 256;
    localparam int IN_USER_W   = 2;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 9'd256;
    localparam logic [7:0]         DOT         = 8'h2E;

    typedef enum logic [1:0] {
        OP_RECORD = 2'd0,
        OP_QADDR  = 2'd1,
        OP_QNAME  = 2'd2,
        OP_UNUSED = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        K_HEADER   = 3'd0,
        K_ASSOC    = 3'd1,
        K_NOTFOUND = 3'd2,
        K_INVALID  = 3'd3,
        K_RECORDED = 3'd4,
        K_IGNORED  = 3'd5
    } t_kind;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHK,
        S_TRIM,
        S_QSTART,
        S_SCAN,
        S_HDR,
        S_AS_RD,
        S_AS_CHK,
        S_ENT_WR,
        S_APPEND,
        S_NEXT,
        S_SINGLE,
        S_FIN
    } t_state;

    // entry word: key text, key length, total count, associates in use
    typedef struct packed {
        logic [TXT_W-1:0] txt;
        logic [LEN_W-1:0] len;
        logic [CNT_W-1:0] total;
        logic [NA_W-1:0]  na;
    } t_ent;

    // associate word: text, length, count
    typedef struct packed {
        logic [TXT_W-1:0] txt;
        logic [LEN_W-1:0] len;
        logic [CNT_W-1:0] cnt;
    } t_asc;

    // one result on its way to the output stage
    typedef struct packed {
        t_kind            kind;
        logic [TXT_W-1:0] txt;
        logic [LEN_W-1:0] len;
        logic [CNT_W-1:0] cnt;
        logic [NA_W-1:0]  tot;
    } t_res;

    // byte mask keeping the first len bytes (byte 0 at the top)
    function automatic logic [TXT_W-1:0] txt_mask(input logic [LEN_W-1:0] len);
        logic [TXT_W-1:0] m;
        m = '0;
        for (int k = 0; k < TXT_BYTES; k++) begin
            if (LEN_W'(k) < len) m[TXT_W-1-8*k -: 8] = 8'hFF;
        end
        return m;
    endfunction

    // position of the last dot below len, zero when there is none
    function automatic logic [LEN_W-1:0] last_dot(input logic [TXT_W-1:0] t,
                                                 input logic [LEN_W-1:0] len);
        logic [LEN_W-1:0] p;
        p = '0;
        for (int k = 0; k < TXT_BYTES; k++) begin
            if (LEN_W'(k) < len && t[TXT_W-1-8*k -: 8] == DOT) p = LEN_W'(k);
        end
        return p;
    endfunction

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v == '1) ? v : v + CNT_W'(1);
    endfunction

endpackage

### design/tac_ram.sv
// ----------------------------------------------------------------------------
// tac_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module tac_ram #(
    parameter int W = 8,
    parameter int D = 2
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [$clog2(D)-1:0] i_waddr,
    input  logic [W-1:0]         i_wdata,
    input  logic                 i_re,
    input  logic [$clog2(D)-1:0] i_raddr,
    output logic [W-1:0]         o_rdata
);

    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
    end

    // read port, data holds while no read is issued
    always_ff @(posedge i_clk) begin
        if (i_re) r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### design/tac_out.sv
// ----------------------------------------------------------------------------
// tac_out
// Result stage: holds one pending result so the final one of an input can be
// marked, and an output register toward the master stream.
// ----------------------------------------------------------------------------
module tac_out (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_push_valid,
    input  tac_pkg::t_res                  i_push,
    output logic                           o_push_ready,
    input  logic                           i_fin,
    input  logic                           i_fin_trunc,
    output logic                           o_fin_ready,
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    // text_hi, text_lo, text_length, hit_count, associate_total
    output logic [tac_pkg::OUT_DATA_W-1:0] o_m_tdata,
    // kind, truncated
    output logic [tac_pkg::OUT_USER_W-1:0] o_m_tuser,
    output logic                           o_m_tlast
);

    logic          r_pv;
    tac_pkg::t_res r_p;
    logic          r_ov;
    tac_pkg::t_res r_o;
    logic          r_last;
    logic          r_trunc;
    logic          can_move;

    assign can_move     = !r_ov || i_m_tready;
    assign o_push_ready = !r_pv || can_move;
    assign o_fin_ready  = can_move;

    // pending slot and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            if (r_ov && i_m_tready) r_ov <= 1'b0;
            if (i_push_valid && o_push_ready) begin
                if (r_pv) begin
                    r_ov    <= 1'b1;
                    r_o     <= r_p;
                    r_last  <= 1'b0;
                    r_trunc <= 1'b0;
                end
                r_pv <= 1'b1;
                r_p  <= i_push;
            end else if (i_fin && can_move) begin
                r_ov    <= 1'b1;
                r_o     <= r_p;
                r_last  <= 1'b1;
                r_trunc <= i_fin_trunc;
                r_pv    <= 1'b0;
            end
        end
    end

    assign o_m_tvalid = r_ov;
    assign o_m_tdata  = {r_o.tot, r_o.cnt, r_o.len, r_o.txt[55:0], r_o.txt[119:56]};
    assign o_m_tuser  = {r_trunc, r_o.kind};
    assign o_m_tlast  = r_last;

endmodule

### design/two_way_association_counter.sv
// ----------------------------------------------------------------------------
// two_way_association_counter
// Address and name tables with associate lists, kept in entry and associate
// RAMs, driven by a read-modify-write sequencer.
// ----------------------------------------------------------------------------
// A record scans each table for its key, compares the associates of a match,
//   writes or appends the entry and switches to the other table; a query scans
//   its table and emits a header and the associates of each match, or one result
//   when nothing matches. Output stalls hold the sequencer. One input at a time.
// The scan rate is one entry per cycle between matches, set by the entry RAM read port.
// Reset clears counts, fill counts and control; RAM contents are not swept:
//   only entries below the fill counts are ever read, so input is taken at once.
// ----------------------------------------------------------------------------
module two_way_association_counter #(
    parameter int ENTRIES         = tac_pkg::DEF_ENTRIES,
    parameter int ASSOC_PER_ENTRY = tac_pkg::DEF_ASSOC
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    // name_text_hi, name_text_lo, name_length, addr_text_hi, addr_text_lo,
    // addr_length, cutoff, zero pad
    input  logic [tac_pkg::IN_DATA_W-1:0]   i_s_tdata,
    // opcode
    input  logic [tac_pkg::IN_USER_W-1:0]   i_s_tuser,
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    // text_hi, text_lo, text_length, hit_count, associate_total
    output logic [tac_pkg::OUT_DATA_W-1:0]  o_m_tdata,
    // kind, truncated
    output logic [tac_pkg::OUT_USER_W-1:0]  o_m_tuser,
    output logic                            o_m_tlast,
    input  logic                            i_cfg_we,
    input  logic [tac_pkg::LIMIT_W-1:0]     i_cfg_wdata
);

    localparam int CW  = $clog2(ENTRIES + 1);
    localparam int IW  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int EAW = $clog2(2 * ENTRIES);
    localparam int AAW = $clog2(2 * ENTRIES * ASSOC_PER_ENTRY);
    localparam int EW  = $bits(tac_pkg::t_ent);
    localparam int AW  = $bits(tac_pkg::t_asc);

    tac_pkg::t_state r_state, n_state;
    tac_pkg::t_op    r_op;
    tac_pkg::t_kind  r_kind;
    logic [tac_pkg::TXT_W-1:0]   r_name, r_addr, r_q;
    logic [tac_pkg::LEN_W-1:0]   r_nlen, r_alen, r_qlen;
    logic [1:0]                  r_cut, r_trim;
    logic                        r_tab;
    logic [CW-1:0]               r_used [2];
    logic [tac_pkg::LIMIT_W-1:0] r_limit;
    logic [CW-1:0]               r_ia;
    logic                        r_rv;
    logic [IW-1:0]               r_ri;
    logic                        r_found;
    logic [tac_pkg::NA_W-1:0]    r_j;
    logic                        r_app;
    logic [tac_pkg::N_W-1:0]     r_n;
    logic                        r_over;

    // memory ports
    logic           ent_we, ent_re, asc_we, asc_re;
    logic [EAW-1:0] ent_waddr, ent_raddr;
    logic [AAW-1:0] asc_waddr, asc_raddr;
    tac_pkg::t_ent  ent_wdata, e;
    tac_pkg::t_asc  asc_wdata, a;
    logic [EW-1:0]  ent_rdata;
    logic [AW-1:0]  asc_rdata;

    // result stage handshake
    logic          push_req, push_ready, emit_done, fin, fin_ready;
    tac_pkg::t_res push_res;

    // datapath helpers
    logic                      s_acc, is_rec, ent_match, asc_match;
    logic                      scan_hit, scan_done, scan_re, j_last, ignore;
    logic [tac_pkg::TXT_W-1:0] in_name, in_addr, k_txt, p_txt;
    logic [tac_pkg::LEN_W-1:0] k_len, p_len, nl;
    logic [CW-1:0]             used_cur;
    logic [EAW-1:0]            tab_base, m_slot, app_slot;
    logic [AAW-1:0]            m_asc_base, app_asc_base;

    assign e = tac_pkg::t_ent'(ent_rdata);
    assign a = tac_pkg::t_asc'(asc_rdata);

    assign o_s_tready = (r_state == tac_pkg::S_IDLE);
    assign s_acc      = i_s_tvalid && o_s_tready;
    assign in_name    = {i_s_tdata[63:0], i_s_tdata[119:64]};
    assign in_addr    = {i_s_tdata[187:124], i_s_tdata[243:188]};

    // key and partner of the table in work
    assign is_rec   = (r_op == tac_pkg::OP_RECORD);
    assign k_txt    = r_tab ? r_name : r_addr;
    assign k_len    = r_tab ? r_nlen : r_alen;
    assign p_txt    = r_tab ? r_addr : r_name;
    assign p_len    = r_tab ? r_alen : r_nlen;
    assign used_cur = r_used[r_tab];

    assign ignore = (r_nlen == '0) || (r_alen == '0) ||
                    (32'(r_used[0]) >= 32'(r_limit)) || (32'(r_used[0]) >= 32'(ENTRIES)) ||
                    (32'(r_used[1]) >= 32'(r_limit)) || (32'(r_used[1]) >= 32'(ENTRIES));

    // entry compare: exact key for a record, exact or prefix for a query
    always_comb begin
        if (is_rec) begin
            ent_match = (e.len == k_len) && (e.txt == k_txt);
        end else begin
            ent_match = (e.len >= r_qlen) && ((r_cut != 2'd0) || (e.len == r_qlen)) &&
                        ((e.txt & tac_pkg::txt_mask(r_qlen)) == r_q);
        end
    end

    assign asc_match = (a.len == p_len) && (a.txt == p_txt);
    assign scan_hit  = r_rv && ent_match;
    assign scan_done = !r_rv && (r_ia >= used_cur);
    assign scan_re   = (r_state == tac_pkg::S_SCAN) && !scan_hit && (r_ia < used_cur);
    assign j_last    = (r_j + tac_pkg::NA_W'(1)) == e.na;
    assign nl        = tac_pkg::last_dot(r_q, r_qlen);

    // addresses
    assign tab_base     = EAW'(r_tab) * EAW'(ENTRIES);
    assign m_slot       = tab_base + EAW'(r_ri);
    assign app_slot     = tab_base + EAW'(used_cur[IW-1:0]);
    assign m_asc_base   = AAW'(m_slot) * AAW'(ASSOC_PER_ENTRY);
    assign app_asc_base = AAW'(app_slot) * AAW'(ASSOC_PER_ENTRY);

    assign emit_done = push_req && ((r_n == tac_pkg::N_W'(tac_pkg::CAP)) || push_ready);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            tac_pkg::S_IDLE: begin
                if (s_acc) n_state = tac_pkg::S_CHK;
            end
            tac_pkg::S_CHK: begin
                case (r_op)
                    tac_pkg::OP_RECORD: n_state = ignore ? tac_pkg::S_SINGLE : tac_pkg::S_SCAN;
                    tac_pkg::OP_QADDR:  n_state = (r_cut == 2'd1 || r_cut == 2'd2) ?
                                                  tac_pkg::S_TRIM : tac_pkg::S_QSTART;
                    tac_pkg::OP_QNAME:  n_state = tac_pkg::S_QSTART;
                    default:            n_state = tac_pkg::S_SINGLE;
                endcase
            end
            tac_pkg::S_TRIM: begin
                if (r_trim == 2'd1) n_state = tac_pkg::S_QSTART;
            end
            tac_pkg::S_QSTART: begin
                n_state = (used_cur == '0 || r_qlen == '0) ? tac_pkg::S_SINGLE : tac_pkg::S_SCAN;
            end
            tac_pkg::S_SCAN: begin
                if (scan_hit) begin
                    n_state = is_rec ? tac_pkg::S_AS_RD : tac_pkg::S_HDR;
                end else if (scan_done) begin
                    if (is_rec)       n_state = tac_pkg::S_APPEND;
                    else if (r_found) n_state = tac_pkg::S_FIN;
                    else              n_state = tac_pkg::S_SINGLE;
                end
            end
            tac_pkg::S_HDR: begin
                if (emit_done) n_state = (e.na == '0) ? tac_pkg::S_SCAN : tac_pkg::S_AS_RD;
            end
            tac_pkg::S_AS_RD: n_state = tac_pkg::S_AS_CHK;
            tac_pkg::S_AS_CHK: begin
                if (is_rec) begin
                    n_state = (asc_match || j_last) ? tac_pkg::S_ENT_WR : tac_pkg::S_AS_RD;
                end else if (emit_done) begin
                    n_state = j_last ? tac_pkg::S_SCAN : tac_pkg::S_AS_RD;
                end
            end
            tac_pkg::S_ENT_WR: n_state = tac_pkg::S_NEXT;
            tac_pkg::S_APPEND: n_state = tac_pkg::S_NEXT;
            tac_pkg::S_NEXT: begin
                n_state = r_tab ? tac_pkg::S_SINGLE : tac_pkg::S_SCAN;
            end
            tac_pkg::S_SINGLE: begin
                if (emit_done) n_state = tac_pkg::S_FIN;
            end
            tac_pkg::S_FIN: begin
                if (fin_ready) n_state = tac_pkg::S_IDLE;
            end
            default: n_state = tac_pkg::S_IDLE;
        endcase
    end

    // memory controls and result pushes
    always_comb begin
        ent_re    = 1'b0;
        ent_raddr = tab_base + EAW'(r_ia[IW-1:0]);
        ent_we    = 1'b0;
        ent_waddr = m_slot;
        ent_wdata = e;
        asc_re    = 1'b0;
        asc_raddr = m_asc_base + AAW'(r_j);
        asc_we    = 1'b0;
        asc_waddr = m_asc_base + AAW'(r_j);
        asc_wdata = a;
        push_req  = 1'b0;
        push_res  = '0;
        fin       = 1'b0;
        case (r_state)
            tac_pkg::S_SCAN: ent_re = scan_re;
            tac_pkg::S_HDR: begin
                push_req = 1'b1;
                push_res = '{kind: tac_pkg::K_HEADER, txt: e.txt, len: e.len,
                             cnt: e.total, tot: e.na};
            end
            tac_pkg::S_AS_RD: asc_re = 1'b1;
            tac_pkg::S_AS_CHK: begin
                if (is_rec) begin
                    asc_we    = asc_match;
                    asc_wdata = '{txt: a.txt, len: a.len, cnt: tac_pkg::sat_inc(a.cnt)};
                end else begin
                    push_req = 1'b1;
                    push_res = '{kind: tac_pkg::K_ASSOC, txt: a.txt, len: a.len,
                                 cnt: a.cnt, tot: '0};
                end
            end
            tac_pkg::S_ENT_WR: begin
                ent_we    = 1'b1;
                ent_wdata = '{txt: e.txt, len: e.len, total: tac_pkg::sat_inc(e.total),
                              na: e.na + tac_pkg::NA_W'(r_app)};
                asc_we    = r_app;
                asc_waddr = m_asc_base + AAW'(e.na);
                asc_wdata = '{txt: p_txt, len: p_len, cnt: tac_pkg::CNT_W'(1)};
            end
            tac_pkg::S_APPEND: begin
                ent_we    = 1'b1;
                ent_waddr = app_slot;
                ent_wdata = '{txt: k_txt, len: k_len, total: tac_pkg::CNT_W'(1),
                              na: tac_pkg::NA_W'(1)};
                asc_we    = 1'b1;
                asc_waddr = app_asc_base;
                asc_wdata = '{txt: p_txt, len: p_len, cnt: tac_pkg::CNT_W'(1)};
            end
            tac_pkg::S_SINGLE: begin
                push_req = 1'b1;
                push_res.kind = r_kind;
                if (r_kind == tac_pkg::K_NOTFOUND) begin
                    push_res.txt = r_q;
                    push_res.len = r_qlen;
                end
            end
            tac_pkg::S_FIN: fin = 1'b1;
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= tac_pkg::S_IDLE;
            r_used[0] <= '0;
            r_used[1] <= '0;
            r_limit   <= tac_pkg::LIMIT_RESET;
            r_rv      <= 1'b0;
            r_n       <= '0;
            r_over    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) r_limit <= i_cfg_wdata;
            if (emit_done) begin
                if (r_n == tac_pkg::N_W'(tac_pkg::CAP)) r_over <= 1'b1;
                else                                    r_n <= r_n + tac_pkg::N_W'(1);
            end
            case (r_state)
                tac_pkg::S_IDLE: begin
                    if (s_acc) begin
                        r_n    <= '0;
                        r_over <= 1'b0;
                    end
                end
                tac_pkg::S_CHK, tac_pkg::S_QSTART, tac_pkg::S_NEXT: r_rv <= 1'b0;
                tac_pkg::S_SCAN: r_rv <= scan_hit ? 1'b0 : scan_re;
                tac_pkg::S_APPEND: r_used[r_tab] <= used_cur + CW'(1);
                default: ;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            tac_pkg::S_IDLE: begin
                if (s_acc) begin
                    r_op    <= tac_pkg::t_op'(i_s_tuser);
                    r_nlen  <= i_s_tdata[123:120];
                    r_name  <= in_name & tac_pkg::txt_mask(i_s_tdata[123:120]);
                    r_alen  <= i_s_tdata[247:244];
                    r_addr  <= in_addr & tac_pkg::txt_mask(i_s_tdata[247:244]);
                    r_cut   <= i_s_tdata[249:248];
                    r_trim  <= i_s_tdata[249:248];
                    r_tab   <= (tac_pkg::t_op'(i_s_tuser) == tac_pkg::OP_QNAME);
                    r_found <= 1'b0;
                end
            end
            tac_pkg::S_CHK: begin
                r_q    <= r_tab ? r_name : r_addr;
                r_qlen <= r_tab ? r_nlen : r_alen;
                r_ia   <= '0;
                r_kind <= (r_op == tac_pkg::OP_RECORD) ? tac_pkg::K_IGNORED : tac_pkg::K_INVALID;
            end
            tac_pkg::S_TRIM: begin
                r_q    <= r_q & tac_pkg::txt_mask(nl);
                r_qlen <= nl;
                r_trim <= r_trim - 2'd1;
            end
            tac_pkg::S_QSTART: begin
                r_ia   <= '0;
                r_kind <= tac_pkg::K_INVALID;
            end
            tac_pkg::S_SCAN: begin
                if (scan_hit) begin
                    r_j     <= '0;
                    r_found <= 1'b1;
                end else begin
                    if (scan_re) begin
                        r_ri <= r_ia[IW-1:0];
                        r_ia <= r_ia + CW'(1);
                    end
                    if (scan_done) r_kind <= tac_pkg::K_NOTFOUND;
                end
            end
            tac_pkg::S_HDR: begin
                if (emit_done) r_ia <= CW'(r_ri) + CW'(1);
            end
            tac_pkg::S_AS_CHK: begin
                if (is_rec) begin
                    r_app <= !asc_match && (32'(e.na) < 32'(ASSOC_PER_ENTRY));
                    if (!asc_match && !j_last) r_j <= r_j + tac_pkg::NA_W'(1);
                end else if (emit_done) begin
                    r_j  <= r_j + tac_pkg::NA_W'(1);
                    r_ia <= CW'(r_ri) + CW'(1);
                end
            end
            tac_pkg::S_NEXT: begin
                r_tab  <= 1'b1;
                r_ia   <= '0;
                r_kind <= tac_pkg::K_RECORDED;
            end
            default: ;
        endcase
    end

    tac_ram #(.W(EW), .D(2 * ENTRIES)) u_ent_ram (
        .i_clk   (i_clk),
        .i_we    (ent_we),
        .i_waddr (ent_waddr),
        .i_wdata (ent_wdata),
        .i_re    (ent_re),
        .i_raddr (ent_raddr),
        .o_rdata (ent_rdata)
    );

    tac_ram #(.W(AW), .D(2 * ENTRIES * ASSOC_PER_ENTRY)) u_asc_ram (
        .i_clk   (i_clk),
        .i_we    (asc_we),
        .i_waddr (asc_waddr),
        .i_wdata (asc_wdata),
        .i_re    (asc_re),
        .i_raddr (asc_raddr),
        .o_rdata (asc_rdata)
    );

    tac_out u_out (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_req && (r_n != tac_pkg::N_W'(tac_pkg::CAP))),
        .i_push       (push_res),
        .o_push_ready (push_ready),
        .i_fin        (fin),
        .i_fin_trunc  (r_over),
        .o_fin_ready  (fin_ready),
        .o_m_tvalid   (o_m_tvalid),
        .i_m_tready   (i_m_tready),
        .o_m_tdata    (o_m_tdata),
        .o_m_tuser    (o_m_tuser),
        .o_m_tlast    (o_m_tlast)
    );

    // fill counts never pass the table depth
    a_used_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (32'(r_used[0]) <= 32'(ENTRIES)) && (32'(r_used[1]) <= 32'(ENTRIES)))
        else $error("table fill count beyond depth");

    // result counter stops at the cap
    a_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_n <= tac_pkg::N_W'(tac_pkg::CAP))
        else $error("result count beyond cap");

    // every input has produced a result before it is closed
    a_fin_has_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tac_pkg::S_FIN) |-> (r_n != '0))
        else $error("input closed without a result");

    // an entry read never overlaps an entry write
    a_ent_rw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(ent_we && ent_re))
        else $error("entry RAM read and write in one cycle");

endmodule

### tb/two_way_association_counter_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_way_association_counter_test
// Self-checking bench: records and queries are streamed into the block from a
// pending queue, an in-bench copy of both tables predicts every result, and
// the monitor compares each output transaction with the oldest prediction.
// ----------------------------------------------------------------------------
module two_way_association_counter_test;

    localparam int N_ENT      = tac_pkg::DEF_ENTRIES;
    localparam int N_ASC      = tac_pkg::DEF_ASSOC;
    localparam int POOL       = 10;
    localparam int TXT_W      = tac_pkg::TXT_W;
    localparam int TXT_BYTES  = tac_pkg::TXT_BYTES;
    localparam int LEN_W      = tac_pkg::LEN_W;
    localparam int CNT_W      = tac_pkg::CNT_W;
    localparam int NA_W       = tac_pkg::NA_W;
    localparam int CAP        = tac_pkg::CAP;
    localparam int LIMIT_W    = tac_pkg::LIMIT_W;
    localparam int IN_DATA_W  = tac_pkg::IN_DATA_W;
    localparam int IN_USER_W  = tac_pkg::IN_USER_W;
    localparam int OUT_DATA_W = tac_pkg::OUT_DATA_W;
    localparam int OUT_USER_W = tac_pkg::OUT_USER_W;

    typedef struct {
        tac_pkg::t_op     op;
        logic [TXT_W-1:0] ntxt;
        logic [LEN_W-1:0] nlen;
        logic [TXT_W-1:0] atxt;
        logic [LEN_W-1:0] alen;
        logic [1:0]       cut;
    } t_item;

    typedef struct {
        tac_pkg::t_kind   kind;
        logic [TXT_W-1:0] txt;
        logic [LEN_W-1:0] len;
        logic [CNT_W-1:0] cnt;
        logic [NA_W-1:0]  tot;
        logic             last;
        logic             trunc;
    } t_exp;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_s_tvalid;
    logic                  o_s_tready;
    logic [IN_DATA_W-1:0]  i_s_tdata;
    logic [IN_USER_W-1:0]  i_s_tuser;
    logic                  o_m_tvalid;
    logic                  i_m_tready;
    logic [OUT_DATA_W-1:0] o_m_tdata;
    logic [OUT_USER_W-1:0] o_m_tuser;
    logic                  o_m_tlast;
    logic                  i_cfg_we;
    logic [LIMIT_W-1:0]    i_cfg_wdata;

    two_way_association_counter dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .o_m_tlast   (o_m_tlast),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    // table shadow: index 0 keyed by address, 1 keyed by name
    logic [TXT_W-1:0]   key_txt [2][N_ENT];
    logic [LEN_W-1:0]   key_len [2][N_ENT];
    logic [CNT_W-1:0]   key_tot [2][N_ENT];
    int                 key_na  [2][N_ENT];
    logic [TXT_W-1:0]   par_txt [2][N_ENT][N_ASC];
    logic [LEN_W-1:0]   par_len [2][N_ENT][N_ASC];
    logic [CNT_W-1:0]   par_cnt [2][N_ENT][N_ASC];
    int                 fill    [2];
    int                 limit_now;

    t_item pending_q[$];
    t_exp  result_q[$];
    int    errors;
    int    n_out;
    bit    cut_off;
    bit    in_fire;
    int    send_idle_pct;
    int    recv_stall_pct;
    int    hold_req;
    int    hold_cnt;

    logic [TXT_W-1:0] name_pool [POOL];
    logic [LEN_W-1:0] name_plen [POOL];
    logic [TXT_W-1:0] addr_pool [POOL];
    logic [LEN_W-1:0] addr_plen [POOL];

    function automatic logic [TXT_W-1:0] keep_bytes(logic [TXT_W-1:0] t, int n);
        logic [TXT_W-1:0] m;
        m = '0;
        for (int k = 0; k < TXT_BYTES; k++) begin
            if (k < n) m[TXT_W-1-8*k -: 8] = 8'hFF;
        end
        return t & m;
    endfunction

    function automatic logic [TXT_W-1:0] rand_txt();
        return TXT_W'({$urandom, $urandom, $urandom, $urandom});
    endfunction

    // adds one result, dropping anything past the cap
    task automatic add_result(tac_pkg::t_kind k, logic [TXT_W-1:0] t, logic [LEN_W-1:0] n,
                              logic [CNT_W-1:0] c, int tot);
        t_exp r;
        if (n_out >= CAP) begin
            cut_off = 1;
        end else begin
            r.kind = k; r.txt = t; r.len = n; r.cnt = c; r.tot = NA_W'(tot);
            r.last = 0; r.trunc = 0;
            result_q.push_back(r);
            n_out++;
        end
    endtask

    function automatic logic [CNT_W-1:0] bump(logic [CNT_W-1:0] v);
        return (v == '1) ? v : v + 1;
    endfunction

    task automatic store_pair(int tb, logic [TXT_W-1:0] kt, logic [LEN_W-1:0] kl,
                              logic [TXT_W-1:0] pt, logic [LEN_W-1:0] pl);
        int j;
        int na;
        for (int i = 0; i < fill[tb]; i++) begin
            if (key_len[tb][i] == kl && key_txt[tb][i] == kt) begin
                na = key_na[tb][i];
                for (j = 0; j < na; j++) begin
                    if (par_len[tb][i][j] == pl && par_txt[tb][i][j] == pt) begin
                        par_cnt[tb][i][j] = bump(par_cnt[tb][i][j]);
                        break;
                    end
                end
                if (j == na && na < N_ASC) begin
                    par_txt[tb][i][na] = pt; par_len[tb][i][na] = pl;
                    par_cnt[tb][i][na] = 1;
                    key_na[tb][i] = na + 1;
                end
                key_tot[tb][i] = bump(key_tot[tb][i]);
                return;
            end
        end
        if (fill[tb] < N_ENT) begin
            na = fill[tb];
            key_txt[tb][na] = kt; key_len[tb][na] = kl; key_tot[tb][na] = 1;
            key_na[tb][na] = 1;
            par_txt[tb][na][0] = pt; par_len[tb][na][0] = pl; par_cnt[tb][na][0] = 1;
            fill[tb] = na + 1;
        end
    endtask

    // works out every result of one accepted transaction
    task automatic predict_results(t_item it);
        logic [TXT_W-1:0] nt, at, qt;
        int nl, al, ql, tb, dot_at, lim;
        bit hit;
        n_out = 0;
        cut_off = 0;
        nl = it.nlen; al = it.alen;
        nt = keep_bytes(it.ntxt, nl);
        at = keep_bytes(it.atxt, al);
        lim = (limit_now < N_ENT) ? limit_now : N_ENT;
        if (it.op == tac_pkg::OP_RECORD) begin
            if (nl == 0 || al == 0 || fill[0] >= lim || fill[1] >= lim) begin
                add_result(tac_pkg::K_IGNORED, '0, '0, '0, 0);
            end else begin
                store_pair(0, at, al, nt, nl);
                store_pair(1, nt, nl, at, al);
                add_result(tac_pkg::K_RECORDED, '0, '0, '0, 0);
            end
        end else if (it.op == tac_pkg::OP_UNUSED) begin
            add_result(tac_pkg::K_INVALID, '0, '0, '0, 0);
        end else begin
            tb = (it.op == tac_pkg::OP_QADDR) ? 0 : 1;
            qt = tb ? nt : at;
            ql = tb ? nl : al;
            // address queries may drop trailing dotted parts
            if (tb == 0 && (it.cut == 1 || it.cut == 2)) begin
                for (int p = 0; p < it.cut; p++) begin
                    dot_at = 0;
                    for (int k = ql - 1; k >= 0; k--) begin
                        if (qt[TXT_W-1-8*k -: 8] == tac_pkg::DOT) begin
                            dot_at = k;
                            break;
                        end
                    end
                    ql = dot_at;
                    qt = keep_bytes(qt, ql);
                end
            end
            if (fill[tb] == 0 || ql == 0) begin
                add_result(tac_pkg::K_INVALID, '0, '0, '0, 0);
            end else begin
                hit = 0;
                for (int i = 0; i < fill[tb]; i++) begin
                    if (key_len[tb][i] < ql) continue;
                    if (it.cut == 0 && key_len[tb][i] != ql) continue;
                    if (keep_bytes(key_txt[tb][i], ql) != qt) continue;
                    hit = 1;
                    add_result(tac_pkg::K_HEADER, key_txt[tb][i], key_len[tb][i],
                               key_tot[tb][i], key_na[tb][i]);
                    for (int j = 0; j < key_na[tb][i]; j++)
                        add_result(tac_pkg::K_ASSOC, par_txt[tb][i][j], par_len[tb][i][j],
                                   par_cnt[tb][i][j], 0);
                end
                if (!hit) add_result(tac_pkg::K_NOTFOUND, qt, LEN_W'(ql), '0, 0);
            end
        end
        result_q[$].last = 1;
        result_q[$].trunc = cut_off;
    endtask

    // clock
    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    // input driver: one transaction per handshake, changes on the falling edge
    always @(negedge i_clk) begin
        if (i_rst_n && (!i_s_tvalid || in_fire)) begin
            if (pending_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                t_item it;
                it = pending_q.pop_front();
                predict_results(it);
                i_s_tdata <= {6'b0, it.cut, it.alen, it.atxt[55:0], it.atxt[119:56],
                              it.nlen, it.ntxt[55:0], it.ntxt[119:56]};
                i_s_tuser <= it.op;
                i_s_tvalid <= 1'b1;
            end else begin
                i_s_tvalid <= 1'b0;
            end
        end
    end

    // receiver ready, with a long hold-off on request
    always @(negedge i_clk) begin
        if (hold_req > 0) begin
            hold_cnt = hold_req;
            hold_req = 0;
        end
        if (hold_cnt > 0) begin
            hold_cnt = hold_cnt - 1;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // monitor: input handshakes and result checking
    always @(posedge i_clk) begin
        in_fire <= i_s_tvalid && o_s_tready;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (result_q.size() == 0) begin
                $display("%0t: unexpected result, actual kind %0d data %h", $time,
                         o_m_tuser[2:0], o_m_tdata);
                errors++;
            end else begin
                t_exp e;
                e = result_q.pop_front();
                if (o_m_tuser[2:0] !== e.kind || o_m_tuser[3] !== e.trunc ||
                    o_m_tlast !== e.last || o_m_tdata[63:0] !== e.txt[119:56] ||
                    o_m_tdata[119:64] !== e.txt[55:0] || o_m_tdata[123:120] !== e.len ||
                    o_m_tdata[155:124] !== e.cnt || o_m_tdata[159:156] !== e.tot) begin
                    $display("%0t: mismatch expected kind %0d trunc %0d last %0d len %0d",
                             $time, e.kind, e.trunc, e.last, e.len);
                    $display("    text %h count %0d total %0d", e.txt, e.cnt, e.tot);
                    $display("  actual kind %0d trunc %0d last %0d len %0d", o_m_tuser[2:0],
                             o_m_tuser[3], o_m_tlast, o_m_tdata[123:120]);
                    $display("    text %h count %0d total %0d",
                             {o_m_tdata[63:0], o_m_tdata[119:64]}, o_m_tdata[155:124],
                             o_m_tdata[159:156]);
                    errors++;
                end
            end
        end
    end

    // run limit
    initial begin
        #40ms;
        $display("*** FAILED ***");
        $finish;
    end

    task automatic wait_drained();
        while (pending_q.size() > 0 || i_s_tvalid || result_q.size() > 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic set_limit(int v);
        wait_drained();
        @(negedge i_clk);
        i_cfg_we = 1;
        i_cfg_wdata = LIMIT_W'(v);
        @(negedge i_clk);
        i_cfg_we = 0;
        limit_now = v;
    endtask

    task automatic queue_item(tac_pkg::t_op op, logic [TXT_W-1:0] nt, int nl,
                              logic [TXT_W-1:0] at, int al, int cut);
        t_item it;
        it.op = op; it.ntxt = nt; it.nlen = LEN_W'(nl);
        it.atxt = at; it.alen = LEN_W'(al); it.cut = 2'(cut);
        pending_q.push_back(it);
    endtask

    // pool text from a small alphabet; addresses carry dots
    function automatic logic [TXT_W-1:0] pool_txt(int n, bit dotted);
        logic [TXT_W-1:0] t;
        byte chars [4];
        if (dotted) begin
            chars[0] = "1"; chars[1] = "2"; chars[2] = "."; chars[3] = ".";
        end else begin
            chars[0] = "a"; chars[1] = "b"; chars[2] = "c"; chars[3] = ".";
        end
        t = '0;
        for (int k = 0; k < n; k++) t[TXT_W-1-8*k -: 8] = chars[$urandom_range(3)];
        return t;
    endfunction

    // garbage past the length must be ignored by the block
    function automatic logic [TXT_W-1:0] smear(logic [TXT_W-1:0] t, int n);
        logic [TXT_W-1:0] g;
        g = rand_txt();
        return t | (g & ~keep_bytes('1, n));
    endfunction

    task automatic queue_random();
        int r, ni, ai, ql;
        r = $urandom_range(99);
        ni = $urandom_range(POOL - 1);
        ai = $urandom_range(POOL - 1);
        if (r < 60) begin
            queue_item(tac_pkg::OP_RECORD, smear(name_pool[ni], name_plen[ni]),
                       name_plen[ni], smear(addr_pool[ai], addr_plen[ai]), addr_plen[ai],
                       $urandom_range(3));
        end else if (r < 72) begin
            ql = $urandom_range(1, name_plen[ni]);
            queue_item(tac_pkg::OP_QNAME, smear(name_pool[ni], ql), ql, rand_txt(),
                       $urandom_range(15), $urandom_range(3));
        end else if (r < 86) begin
            ql = $urandom_range(1, addr_plen[ai]);
            queue_item(tac_pkg::OP_QADDR, rand_txt(), $urandom_range(15),
                       smear(addr_pool[ai], ql), ql, $urandom_range(3));
        end else begin
            queue_item(tac_pkg::t_op'($urandom_range(3)), rand_txt(), $urandom_range(15),
                       rand_txt(), $urandom_range(15), $urandom_range(3));
        end
    endtask

    task automatic set_idling(int s, int r);
        wait_drained();
        send_idle_pct = s;
        recv_stall_pct = r;
    endtask

    initial begin
        logic [TXT_W-1:0] ones, dots;
        i_rst_n = 0; i_s_tvalid = 0; i_s_tdata = '0; i_s_tuser = '0;
        i_m_tready = 0; i_cfg_we = 0; i_cfg_wdata = '0;
        in_fire = 0; errors = 0; hold_req = 0; hold_cnt = 0;
        send_idle_pct = 0; recv_stall_pct = 0;
        limit_now = tac_pkg::LIMIT_RESET;
        fill[0] = 0; fill[1] = 0;
        for (int p = 0; p < POOL; p++) begin
            name_plen[p] = LEN_W'($urandom_range(1, 15));
            addr_plen[p] = LEN_W'($urandom_range(1, 15));
            name_pool[p] = pool_txt(name_plen[p], 0);
            addr_pool[p] = pool_txt(addr_plen[p], 1);
        end
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;

        ones = '1;
        dots = {"1.2.3.4", 64'h0};
        // directed: queries and an unused opcode on empty tables, then a limit of one
        queue_item(tac_pkg::OP_QADDR, '0, 0, dots, 7, 0);
        queue_item(tac_pkg::OP_QNAME, ones, 15, '0, 0, 0);
        queue_item(tac_pkg::OP_UNUSED, ones, 15, ones, 15, 3);
        set_limit(1);
        queue_item(tac_pkg::OP_RECORD, ones, 15, ones, 15, 0);
        queue_item(tac_pkg::OP_RECORD, ones, 15, ones, 15, 0);
        queue_item(tac_pkg::OP_RECORD, {"x", 112'h0}, 1, dots, 7, 0);
        set_limit(tac_pkg::LIMIT_RESET);
        // empty texts are ignored; extremes of text and length
        queue_item(tac_pkg::OP_RECORD, '0, 0, dots, 7, 0);
        queue_item(tac_pkg::OP_RECORD, ones, 15, '0, 0, 0);
        queue_item(tac_pkg::OP_RECORD, {"x", 112'h0}, 1, dots, 7, 0);
        queue_item(tac_pkg::OP_RECORD, {"y", 112'h0}, 1, dots, 7, 0);
        queue_item(tac_pkg::OP_RECORD, {"x", 112'h0}, 1, {"1.2.9", 80'h0}, 5, 0);
        // exact, prefix and trimmed address queries, then name queries
        queue_item(tac_pkg::OP_QADDR, '0, 0, dots, 7, 0);
        queue_item(tac_pkg::OP_QADDR, '0, 0, dots, 5, 0);
        queue_item(tac_pkg::OP_QADDR, '0, 0, dots, 7, 1);
        queue_item(tac_pkg::OP_QADDR, '0, 0, dots, 7, 2);
        queue_item(tac_pkg::OP_QADDR, '0, 0, dots, 7, 3);
        queue_item(tac_pkg::OP_QADDR, '0, 0, {"1234", 88'h0}, 4, 1);
        queue_item(tac_pkg::OP_QADDR, '0, 0, {".9", 104'h0}, 2, 1);
        queue_item(tac_pkg::OP_QNAME, {"x", 112'h0}, 1, '0, 0, 0);
        queue_item(tac_pkg::OP_QNAME, {"z", 112'h0}, 1, '0, 0, 2);
        queue_item(tac_pkg::OP_QNAME, ones, 15, '0, 0, 0);
        queue_item(tac_pkg::OP_QNAME, ones, 3, '0, 0, 1);

        // random part over the idling phases, with a middle limit too
        set_idling(0, 0);
        repeat (50) queue_random();
        set_limit(200);
        set_idling(65, 0);
        repeat (45) queue_random();
        set_idling(0, 65);
        repeat (10) queue_random();
        wait_drained();
        // long receiver hold-off while items keep coming
        @(posedge i_clk);
        hold_req = 400;
        repeat (35) queue_random();
        set_limit(tac_pkg::LIMIT_RESET);
        set_idling(38, 38);
        repeat (25) queue_random();
        // sender pauses until every result is in
        wait_drained();
        repeat (25) queue_random();
        set_idling(0, 0);
        repeat (20) queue_random();

        wait_drained();
        repeat (100) @(posedge i_clk);
        if (errors == 0 && result_q.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

### filelist.f
design/tac_pkg.sv
design/tac_ram.sv
design/tac_out.sv
design/two_way_association_counter.sv
tb/two_way_association_counter_test.sv
